// ===== src/worst_fit_block_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Worst-fit block allocator assertion macros
// Shared concurrent assertion forms used by the allocator modules.
// ----------------------------------------------------------------------------
`ifndef WORST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define WORST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define WFBA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define WFBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/wfba_pkg.sv =====
// ----------------------------------------------------------------------------
// wfba_pkg
// Types and codes shared by the worst-fit allocator controller and datapath.
// ----------------------------------------------------------------------------
package wfba_pkg;

   // fixed field widths of the word ports
   localparam int SIZE_W   = 16;
   localparam int TOTAL_W  = 20;
   localparam int STATUS_W = 2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_LOADED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_GRANTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_WAIT    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

   // operation codes
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   // controller states
   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_LOAD,
      CTL_SCAN,
      CTL_DRAIN,
      CTL_DECIDE,
      CTL_REPORT
   } ctl_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;    // latch the incoming word, restart the scan
      logic load;       // append a block to the table
      logic scan_read;  // read the next table entry
      logic decide;     // grant or record a waiting request
      logic report;     // register the result word
   } wfba_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic table_empty;
      logic scan_last;
   } wfba_stat_type;

endpackage

// ===== src/wfba_ctrl.sv =====
// ----------------------------------------------------------------------------
// wfba_ctrl
// Sequencer for the worst-fit allocator: load, scan, decide and report.
// ----------------------------------------------------------------------------
`include "worst_fit_block_allocator_assert.svh"

module wfba_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    req_operation,
   input  wfba_pkg::wfba_stat_type stat,
   output wfba_pkg::wfba_cmd_type  cmd,
   output logic                    busy
);
   import wfba_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;
   logic          accept;

   assign accept = start && (state_ff == CTL_IDLE);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTL_IDLE: begin
            if (accept) begin
               if (req_operation == OP_LOAD) begin
                  state_in = CTL_LOAD;
               end else if (stat.table_empty) begin
                  state_in = CTL_DECIDE;
               end else begin
                  state_in = CTL_SCAN;
               end
            end
         end
         CTL_LOAD: begin
            state_in = CTL_REPORT;
         end
         CTL_SCAN: begin
            if (stat.scan_last) begin
               state_in = CTL_DRAIN;
            end
         end
         CTL_DRAIN: begin
            state_in = CTL_DECIDE;
         end
         CTL_DECIDE: begin
            state_in = CTL_REPORT;
         end
         CTL_REPORT: begin
            state_in = CTL_IDLE;
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd           = '0;
      busy          = 1'b1;
      unique case (state_ff)
         CTL_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         CTL_LOAD:   cmd.load      = 1'b1;
         CTL_SCAN:   cmd.scan_read = 1'b1;
         CTL_DRAIN:  cmd           = '0;
         CTL_DECIDE: cmd.decide    = 1'b1;
         CTL_REPORT: cmd.report    = 1'b1;
         default:    cmd           = '0;
      endcase
   end

   `WFBA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted word did not raise busy")
   `WFBA_ASSERT_SAME(a_scan_nonempty, clock, reset, state_ff == CTL_SCAN, !stat.table_empty, "scan over an empty table")

endmodule

// ===== src/wfba_datapath.sv =====
// ----------------------------------------------------------------------------
// wfba_datapath
// Block size memory, used marks, scan tracker, running totals and result word.
// ----------------------------------------------------------------------------
`include "worst_fit_block_allocator_assert.svh"

module wfba_datapath #(
   parameter int MAX_BLOCKS = 16,
   parameter int SIZE_BITS  = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wfba_pkg::wfba_cmd_type                cmd,
   output wfba_pkg::wfba_stat_type               stat,
   input  logic [wfba_pkg::SIZE_W-1:0]           req_size,
   output logic                                  rsp_valid,
   output logic [wfba_pkg::STATUS_W-1:0]         rsp_status,
   output logic [wfba_pkg::SIZE_W-1:0]           rsp_granted_size,
   output logic [wfba_pkg::TOTAL_W-1:0]          rsp_internal_frag_total,
   output logic [wfba_pkg::TOTAL_W-1:0]          rsp_free_total,
   output logic                                  rsp_external_frag_present
);
   import wfba_pkg::*;

   localparam int ADDR_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int SUM_W  = SIZE_BITS + $clog2(MAX_BLOCKS) + 1;

   // block size memory
   logic [SIZE_BITS-1:0] block_mem [MAX_BLOCKS];
   logic [SIZE_BITS-1:0] rd_data_ff;

   logic [SIZE_BITS+SIZE_W-1:0]  size_wide;
   logic [SIZE_BITS-1:0]         size_val;
   logic [SIZE_BITS-1:0]         req_size_ff, req_size_in;
   logic [CNT_W-1:0]             loaded_ff, loaded_in;
   logic [MAX_BLOCKS-1:0]        used_ff, used_in;
   logic [ADDR_W-1:0]            scan_idx_ff, scan_idx_in;
   logic                         pend_valid_ff, pend_valid_in;
   logic [ADDR_W-1:0]            pend_idx_ff, pend_idx_in;
   logic                         found_ff, found_in;
   logic [ADDR_W-1:0]            best_idx_ff, best_idx_in;
   logic [SIZE_BITS-1:0]         best_size_ff, best_size_in;
   logic [SUM_W-1:0]             frag_sum_ff, frag_sum_in;
   logic [SUM_W-1:0]             alloc_sum_ff, alloc_sum_in;
   logic [SUM_W-1:0]             mem_sum_ff, mem_sum_in;
   logic [SIZE_BITS-1:0]         small_wait_ff, small_wait_in;
   logic                         any_wait_ff, any_wait_in;
   logic [STATUS_W-1:0]          status_ff, status_in;
   logic [SIZE_BITS-1:0]         granted_ff, granted_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]          rsp_status_ff, rsp_status_in;
   logic [SIZE_W-1:0]            rsp_granted_ff, rsp_granted_in;
   logic [TOTAL_W-1:0]           rsp_frag_ff, rsp_frag_in;
   logic [TOTAL_W-1:0]           rsp_free_ff, rsp_free_in;
   logic                         rsp_ext_ff, rsp_ext_in;

   logic                         table_full;
   logic [ADDR_W-1:0]            wr_addr;
   logic                         mem_we;
   logic                         better;
   logic                         fit;
   logic [SUM_W-1:0]             free_mem;
   logic [SIZE_BITS+SIZE_W-1:0]  grant_wide;
   logic [SUM_W+TOTAL_W-1:0]     frag_wide;
   logic [SUM_W+TOTAL_W-1:0]     free_wide;

   // incoming size masked to the storage width
   assign size_wide  = {{SIZE_BITS{1'b0}}, req_size};
   assign size_val   = size_wide[SIZE_BITS-1:0];

   assign table_full = (loaded_ff == CNT_W'(MAX_BLOCKS));
   assign wr_addr    = loaded_ff[ADDR_W-1:0];
   assign mem_we     = cmd.load && !table_full;

   // scan compare: first free block strictly larger than the best so far
   assign better = pend_valid_ff && !used_ff[pend_idx_ff]
                   && (!found_ff || (rd_data_ff > best_size_ff));
   assign fit    = found_ff && (best_size_ff >= req_size_ff);

   assign free_mem   = mem_sum_ff - alloc_sum_ff;
   assign grant_wide = {{SIZE_W{1'b0}}, granted_ff};
   assign frag_wide  = {{TOTAL_W{1'b0}}, frag_sum_ff};
   assign free_wide  = {{TOTAL_W{1'b0}}, free_mem};

   assign stat.table_empty = (loaded_ff == '0);
   assign stat.scan_last   = ((CNT_W'(scan_idx_ff) + CNT_W'(1)) == loaded_ff);

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         block_mem[wr_addr] <= req_size_ff;
      end
      rd_data_ff <= block_mem[scan_idx_ff];
   end

   // next values
   always_comb begin
      req_size_in   = req_size_ff;
      loaded_in     = loaded_ff;
      used_in       = used_ff;
      scan_idx_in   = scan_idx_ff;
      pend_valid_in = cmd.scan_read;
      pend_idx_in   = scan_idx_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_size_in  = best_size_ff;
      frag_sum_in   = frag_sum_ff;
      alloc_sum_in  = alloc_sum_ff;
      mem_sum_in    = mem_sum_ff;
      small_wait_in = small_wait_ff;
      any_wait_in   = any_wait_ff;
      status_in     = status_ff;
      granted_in    = granted_ff;

      // capture word, restart scan
      if (cmd.capture) begin
         req_size_in = size_val;
         scan_idx_in = '0;
         found_in    = 1'b0;
      end

      if (cmd.scan_read) begin
         scan_idx_in = scan_idx_ff + ADDR_W'(1);
      end

      // track largest free block
      if (better) begin
         found_in     = 1'b1;
         best_idx_in  = pend_idx_ff;
         best_size_in = rd_data_ff;
      end

      // table load
      if (cmd.load) begin
         granted_in = '0;
         if (table_full) begin
            status_in = STATUS_FULL;
         end else begin
            status_in        = STATUS_LOADED;
            used_in[wr_addr] = 1'b0;
            loaded_in        = loaded_ff + CNT_W'(1);
            mem_sum_in       = mem_sum_ff + SUM_W'(req_size_ff);
         end
      end

      // grant or wait
      if (cmd.decide) begin
         if (fit) begin
            status_in            = STATUS_GRANTED;
            granted_in           = best_size_ff;
            used_in[best_idx_ff] = 1'b1;
            frag_sum_in          = frag_sum_ff + SUM_W'(best_size_ff)
                                   - SUM_W'(req_size_ff);
            alloc_sum_in         = alloc_sum_ff + SUM_W'(best_size_ff);
         end else begin
            status_in   = STATUS_WAIT;
            granted_in  = '0;
            any_wait_in = 1'b1;
            if (!any_wait_ff || (req_size_ff < small_wait_ff)) begin
               small_wait_in = req_size_ff;
            end
         end
      end
   end

   // result word
   always_comb begin
      rsp_valid_in   = cmd.report;
      rsp_status_in  = status_ff;
      rsp_granted_in = grant_wide[SIZE_W-1:0];
      rsp_frag_in    = frag_wide[TOTAL_W-1:0];
      rsp_free_in    = free_wide[TOTAL_W-1:0];
      rsp_ext_in     = any_wait_ff && (SUM_W'(small_wait_ff) <= free_mem);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff     <= '0;
         used_ff       <= '0;
         pend_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
         frag_sum_ff   <= '0;
         alloc_sum_ff  <= '0;
         mem_sum_ff    <= '0;
         small_wait_ff <= '1;
         any_wait_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         loaded_ff     <= loaded_in;
         used_ff       <= used_in;
         pend_valid_ff <= pend_valid_in;
         found_ff      <= found_in;
         frag_sum_ff   <= frag_sum_in;
         alloc_sum_ff  <= alloc_sum_in;
         mem_sum_ff    <= mem_sum_in;
         small_wait_ff <= small_wait_in;
         any_wait_ff   <= any_wait_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_size_ff   <= req_size_in;
      scan_idx_ff   <= scan_idx_in;
      pend_idx_ff   <= pend_idx_in;
      best_idx_ff   <= best_idx_in;
      best_size_ff  <= best_size_in;
      status_ff     <= status_in;
      granted_ff    <= granted_in;
      if (cmd.report) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_granted_ff <= rsp_granted_in;
         rsp_frag_ff    <= rsp_frag_in;
         rsp_free_ff    <= rsp_free_in;
         rsp_ext_ff     <= rsp_ext_in;
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_status                = rsp_status_ff;
   assign rsp_granted_size          = rsp_granted_ff;
   assign rsp_internal_frag_total   = rsp_frag_ff;
   assign rsp_free_total            = rsp_free_ff;
   assign rsp_external_frag_present = rsp_ext_ff;

   `WFBA_ASSERT_SAME(a_pend_in_table, clock, reset, pend_valid_ff, CNT_W'(pend_idx_ff) < loaded_ff, "scan read beyond loaded blocks")
   `WFBA_ASSERT_NEXT(a_load_count, clock, reset, cmd.load && !table_full, loaded_ff == $past(loaded_ff) + CNT_W'(1), "load did not advance block count")
   `WFBA_ASSERT_SAME(a_alloc_le_mem, clock, reset, 1'b1, alloc_sum_ff <= mem_sum_ff, "granted memory exceeds loaded memory")

endmodule

// ===== src/worst_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// worst_fit_block_allocator
// Worst-fit allocator over a table of fixed memory blocks.
// ----------------------------------------------------------------------------
// Pulse start with a word while busy is low; the word is taken at that edge.
// A load (operation 0) appends one block size to the table, or reports full
// when the table is full, and returns its result word by way of the LOAD and
// REPORT states. A request (operation 1) walks the loaded blocks one per cycle
// through the single read port of the block size memory and takes the largest
// free block if it is large enough; it skips the scan when the table is empty.
// busy stays high until the result word is on the rsp_ ports, which hold it
// for exactly one cycle under rsp_valid; the receiver cannot stall, so it must
// take the word in that cycle. A new word may be started in the cycle that
// carries the previous result. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module worst_fit_block_allocator #(
   parameter int MAX_BLOCKS = 16,
   parameter int SIZE_BITS  = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_operation,
   input  logic [wfba_pkg::SIZE_W-1:0]           req_size,
   output logic                                  rsp_valid,
   output logic [wfba_pkg::STATUS_W-1:0]         rsp_status,
   output logic [wfba_pkg::SIZE_W-1:0]           rsp_granted_size,
   output logic [wfba_pkg::TOTAL_W-1:0]          rsp_internal_frag_total,
   output logic [wfba_pkg::TOTAL_W-1:0]          rsp_free_total,
   output logic                                  rsp_external_frag_present
);
   import wfba_pkg::*;

   wfba_cmd_type  cmd;
   wfba_stat_type stat;

   // sequencer
   wfba_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .stat          (stat),
      .cmd           (cmd),
      .busy          (busy)
   );

   // table, scan and totals
   wfba_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_datapath (
      .clock                     (clock),
      .reset                     (reset),
      .cmd                       (cmd),
      .stat                      (stat),
      .req_size                  (req_size),
      .rsp_valid                 (rsp_valid),
      .rsp_status                (rsp_status),
      .rsp_granted_size          (rsp_granted_size),
      .rsp_internal_frag_total   (rsp_internal_frag_total),
      .rsp_free_total            (rsp_free_total),
      .rsp_external_frag_present (rsp_external_frag_present)
   );

endmodule

// ===== tb/sv/worst_fit_block_allocator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// worst_fit_block_allocator_test
// Self-checking bench for the worst-fit block allocator. A scoreboard class
// tracks the block table and running totals, predicts the result word for
// each accepted load or request, and compares every result field against it.
// A short directed sequence covers the corner cases; random traffic follows.
// ----------------------------------------------------------------------------
module worst_fit_block_allocator_test;
   import wfba_pkg::*;

   localparam int TABLE_DEPTH   = 16;
   localparam int RANDOM_WORDS  = 1080;
   localparam int QUIET_WORDS   = 150;   // final stretch without sender gaps
   localparam int ZERO_REQ_WORDS = 100;  // random zero-size requests only near the end
   localparam int DRAIN_CYCLES  = 30;
   localparam int STALL_LIMIT   = 1000;
   localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

   // one result word
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SIZE_W-1:0]   granted_size;
      logic [TOTAL_W-1:0]  frag_total;
      logic [TOTAL_W-1:0]  free_total;
      logic                ext_frag;
   } alloc_word_type;

   // allocator state tracking and result checking
   class alloc_scoreboard;
      alloc_word_type    expected_q[$];
      logic [SIZE_W-1:0] block_size [TABLE_DEPTH];
      bit                block_taken [TABLE_DEPTH];
      int unsigned       blocks_loaded;
      logic [TOTAL_W:0]  frag_sum;
      logic [TOTAL_W:0]  granted_sum;
      logic [TOTAL_W:0]  memory_sum;
      logic [SIZE_W-1:0] smallest_wait;
      bit                any_wait;
      int unsigned       mismatches;

      function new();
         foreach (block_size[i]) begin
            block_size[i]  = '0;
            block_taken[i] = 1'b0;
         end
         blocks_loaded = 0;
         frag_sum      = '0;
         granted_sum   = '0;
         memory_sum    = '0;
         smallest_wait = SIZE_MAX;
         any_wait      = 1'b0;
         mismatches    = 0;
      endfunction

      // first-loaded largest free block, or -1 when none is free
      function int largest_free_index();
         int best;
         best = -1;
         for (int i = 0; i < blocks_loaded; i++) begin
            if (!block_taken[i] && (best < 0 || block_size[i] > block_size[best]))
               best = i;
         end
         return best;
      endfunction

      function int largest_free_size();
         int best;
         best = largest_free_index();
         return (best < 0) ? -1 : int'(block_size[best]);
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // update the table for an accepted word and queue its result
      function void note_word(logic op, logic [SIZE_W-1:0] size);
         alloc_word_type   res;
         int               best;
         logic [TOTAL_W:0] free_mem;
         res = '0;
         if (op == OP_LOAD) begin
            if (blocks_loaded >= TABLE_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               block_size[blocks_loaded]  = size;
               block_taken[blocks_loaded] = 1'b0;
               blocks_loaded++;
               memory_sum += size;
               res.status = STATUS_LOADED;
            end
         end else begin
            best = largest_free_index();
            if (best >= 0 && block_size[best] >= size) begin
               block_taken[best] = 1'b1;
               frag_sum    += block_size[best] - size;
               granted_sum += block_size[best];
               res.status       = STATUS_GRANTED;
               res.granted_size = block_size[best];
            end else begin
               if (!any_wait || size < smallest_wait)
                  smallest_wait = size;
               any_wait   = 1'b1;
               res.status = STATUS_WAIT;
            end
         end
         free_mem       = memory_sum - granted_sum;
         res.frag_total = frag_sum[TOTAL_W-1:0];
         res.free_total = free_mem[TOTAL_W-1:0];
         res.ext_frag   = any_wait && (smallest_wait <= free_mem);
         expected_q.push_back(res);
      endfunction

      function void flag(string what, logic [TOTAL_W-1:0] exp_val,
                         logic [TOTAL_W-1:0] act_val);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: mismatch on %s: expected %0d, got %0d",
                     $realtime, what, exp_val, act_val);
      endfunction

      // compare a result word against the oldest prediction
      function void check_result(alloc_word_type got);
         alloc_word_type exp_word;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result word with no word pending", $realtime);
            return;
         end
         exp_word = expected_q.pop_front();
         if (got.status != exp_word.status)
            flag("status", exp_word.status, got.status);
         if (got.granted_size != exp_word.granted_size)
            flag("granted_size", exp_word.granted_size, got.granted_size);
         if (got.frag_total != exp_word.frag_total)
            flag("internal_frag_total", exp_word.frag_total, got.frag_total);
         if (got.free_total != exp_word.free_total)
            flag("free_total", exp_word.free_total, got.free_total);
         if (got.ext_frag != exp_word.ext_frag)
            flag("external_frag_present", exp_word.ext_frag, got.ext_frag);
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_operation = OP_LOAD;
   logic [SIZE_W-1:0]   req_size = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [SIZE_W-1:0]   rsp_granted_size;
   logic [TOTAL_W-1:0]  rsp_internal_frag_total;
   logic [TOTAL_W-1:0]  rsp_free_total;
   logic                rsp_external_frag_present;

   alloc_scoreboard sb = new();
   int              stall_cycles = 0;

   worst_fit_block_allocator #(
      .MAX_BLOCKS (TABLE_DEPTH),
      .SIZE_BITS  (SIZE_W)
   ) dut (
      .clock                     (clock),
      .reset                     (reset),
      .start                     (start),
      .busy                      (busy),
      .req_operation             (req_operation),
      .req_size                  (req_size),
      .rsp_valid                 (rsp_valid),
      .rsp_status                (rsp_status),
      .rsp_granted_size          (rsp_granted_size),
      .rsp_internal_frag_total   (rsp_internal_frag_total),
      .rsp_free_total            (rsp_free_total),
      .rsp_external_frag_present (rsp_external_frag_present)
   );

   always #5 clock = ~clock;

   // result monitor: every strobed word is taken at the edge ending its cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result({rsp_status, rsp_granted_size, rsp_internal_frag_total,
                          rsp_free_total, rsp_external_frag_present});
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // present one word and hold it until the allocator takes it; start stays
   // high afterwards so a following word can go out back to back
   task automatic send_word(logic op, logic [SIZE_W-1:0] size);
      req_operation <= op;
      req_size      <= size;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_word(op, size);
   endtask

   // occasional random sender gap with start low, none when quiet
   task automatic sender_gap(bit quiet);
      if (!quiet && $urandom_range(3, 0) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(9, 1)) @(posedge clock);
      end
   endtask

   // random request size around the largest free block
   function automatic logic [SIZE_W-1:0] pick_request(bit allow_zero);
      int biggest;
      int lo;
      int pick;
      biggest = sb.largest_free_size();
      lo      = allow_zero ? 0 : 1;
      pick    = $urandom_range(9, 0);
      if (pick <= 3 && biggest >= lo)
         return SIZE_W'($urandom_range(biggest, lo));
      if (pick <= 6 && biggest >= 0 && biggest < int'(SIZE_MAX))
         return SIZE_W'($urandom_range(int'(SIZE_MAX), biggest + 1));
      return SIZE_W'($urandom_range(int'(SIZE_MAX), lo));
   endfunction

   initial begin
      bit                quiet;
      logic              op;
      logic [SIZE_W-1:0] size;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      send_word(OP_REQUEST, SIZE_MAX);   // empty table: waits
      sender_gap(1'b0);
      send_word(OP_LOAD, SIZE_MAX);      // largest block, waiting one now fits
      send_word(OP_REQUEST, SIZE_MAX);   // exact fit
      send_word(OP_LOAD, '0);            // zero-size block
      sender_gap(1'b0);
      send_word(OP_REQUEST, '0);         // zero request on the zero block
      send_word(OP_REQUEST, 16'd1);      // exhausted table: waits
      send_word(OP_LOAD, 16'd1000);
      send_word(OP_LOAD, 16'd1000);      // tie with the previous block
      sender_gap(1'b0);
      send_word(OP_LOAD, 16'd500);
      send_word(OP_REQUEST, 16'd600);    // first of the tied pair
      send_word(OP_REQUEST, 16'd999);
      send_word(OP_REQUEST, 16'd501);    // only the small block left: waits
      sender_gap(1'b0);
      send_word(OP_REQUEST, 16'd500);
      send_word(OP_LOAD, 16'h5555);      // load after requests
      send_word(OP_REQUEST, 16'haaaa);   // too big: waits
      send_word(OP_REQUEST, 16'h1234);

      // random traffic; the table fills slowly, then loads report full
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         quiet = (i >= RANDOM_WORDS - QUIET_WORDS);
         if (sb.blocks_loaded < TABLE_DEPTH)
            op = (i > 700 || $urandom_range(31, 0) == 0) ? OP_LOAD : OP_REQUEST;
         else
            op = ($urandom_range(39, 0) == 0) ? OP_LOAD : OP_REQUEST;
         if (op == OP_LOAD)
            size = $urandom_range(1, 0) ? SIZE_W'($urandom_range(int'(SIZE_MAX), 0))
                                        : SIZE_W'($urandom_range(4095, 0));
         else
            size = pick_request(i >= RANDOM_WORDS - ZERO_REQ_WORDS);
         send_word(op, size);
         sender_gap(quiet);
      end
      start <= 1'b0;

      // drain outstanding results, then allow for a late stray word
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
